@@ hw/rtl/ftpep_pkg.sv @@
// Package for the FTP endpoint parser: character codes, field limits,
// error codes and line-phase encoding. No dependencies.
`timescale 1ns / 1ps

package ftpep_pkg;

    // Character codes
    localparam logic [7:0] CHAR_OPEN  = 8'h28;  // '('
    localparam logic [7:0] CHAR_CLOSE = 8'h29;  // ')'
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'

    // Number limits and field counts
    localparam logic [8:0]  NUM_SAT     = 9'd256;
    localparam logic [11:0] NUM_SAT_EXT = 12'd256;
    localparam logic [11:0] RADIX       = 12'd10;
    localparam logic [2:0]  ADDR_FIELDS = 3'd4;
    localparam logic [2:0]  NUM_FIELDS  = 3'd6;
    localparam logic [2:0]  COUNT_MAX   = 3'd7;

    // Line mode register values
    localparam logic MODE_PORT = 1'b0;
    localparam logic MODE_PASV = 1'b1;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_NO_PAREN = 2'd1,
        ERR_FEW_NUMS = 2'd2,
        ERR_RANGE    = 2'd3
    } t_err;

    // Position relative to the parenthesized list
    typedef enum logic [1:0] {
        PH_BEFORE = 2'd0,
        PH_INSIDE = 2'd1,
        PH_AFTER  = 2'd2
    } t_phase;

endpackage

@@ hw/rtl/ftp_endpoint_parser_core.sv @@
// FTP endpoint parser: byte register, single-cycle line-state update and a result
// register. Depends on ftpep_pkg.
// The result request is loaded into the result register when its end-of-line byte leaves
// the byte register, and it is held there until it is taken.
// Throughput: one byte per cycle; only an end-of-line byte waits, while a result stalls.
// Reset: synchronous, active low; clears line state, both valid flags and line_mode.
`timescale 1ns / 1ps

module ftp_endpoint_parser_core
    import ftpep_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_byte,
    input  logic        i_end_of_line,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_line_mode,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_error_code,
    output logic [31:0] o_ip_address,
    output logic [15:0] o_port_number
);

    // Configuration
    logic r_line_mode;

    // Byte register
    logic       r_s1_valid;
    logic [7:0] r_s1_char;
    logic       r_s1_eol;

    // Line state
    t_phase      r_phase,       n_phase;
    logic [8:0]  r_digit_value, n_digit_value;
    logic        r_in_digits,   n_in_digits;
    logic [2:0]  r_count,       n_count;
    logic        r_fault,       n_fault;
    logic [31:0] r_addr,        n_addr;
    logic [15:0] r_port,        n_port;

    // Result register
    logic        r_out_valid;
    logic [1:0]  r_err;
    logic [31:0] r_ip;
    logic [15:0] r_portnum;

    // Handshake
    logic out_free, advance, accept, load_out;

    // Byte decode
    logic        is_digit, counting, take_digit, finish;
    logic [11:0] prod;
    logic [8:0]  run_value, fin_value;
    t_phase      phase_upd;
    t_err        err_code;

    assign o_cfg_ready = 1'b1;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && (!r_s1_eol || out_free);
    assign o_in_stall = r_s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;
    assign load_out   = advance && r_s1_eol;

    // Classify the byte and extend the digit run
    always_comb begin
        is_digit   = (r_s1_char >= CHAR_ZERO) && (r_s1_char <= CHAR_NINE);
        counting   = (r_line_mode == MODE_PORT) || (r_phase == PH_INSIDE);
        take_digit = is_digit && counting;
        prod       = 12'(r_digit_value) * RADIX + 12'(r_s1_char - CHAR_ZERO);
        run_value  = (prod > NUM_SAT_EXT) ? NUM_SAT : prod[8:0];
        // at most one number closes per byte
        finish     = take_digit ? r_s1_eol : r_in_digits;
        fin_value  = take_digit ? run_value : r_digit_value;
    end

    // Update the line state for one byte
    always_comb begin
        phase_upd = r_phase;
        if (!take_digit && r_line_mode == MODE_PASV) begin
            if (r_phase == PH_BEFORE && r_s1_char == CHAR_OPEN) begin
                phase_upd = PH_INSIDE;
            end else if (r_phase == PH_INSIDE && r_s1_char == CHAR_CLOSE) begin
                phase_upd = PH_AFTER;
            end
        end

        n_phase       = phase_upd;
        n_digit_value = take_digit ? run_value : r_digit_value;
        n_in_digits   = take_digit || r_in_digits;
        n_count       = r_count;
        n_fault       = r_fault;
        n_addr        = r_addr;
        n_port        = r_port;

        if (finish) begin
            n_fault = r_fault || fin_value[8];
            if (r_count < ADDR_FIELDS) begin
                n_addr = {r_addr[23:0], fin_value[7:0]};
            end else if (r_count < NUM_FIELDS) begin
                n_port = {r_port[7:0], fin_value[7:0]};
            end
            if (r_count < COUNT_MAX) begin
                n_count = r_count + 3'd1;
            end
            n_digit_value = '0;
            n_in_digits   = 1'b0;
        end

        priority if (r_line_mode == MODE_PASV && n_phase != PH_AFTER) begin
            err_code = ERR_NO_PAREN;
        end else if (n_count < NUM_FIELDS) begin
            err_code = ERR_FEW_NUMS;
        end else if (n_fault) begin
            err_code = ERR_RANGE;
        end else begin
            err_code = ERR_OK;
        end
    end

    // Hold the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode <= MODE_PORT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_line_mode <= i_cfg_line_mode;
        end
    end

    // Capture an accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
        if (accept) begin
            r_s1_char <= i_char_byte;
            r_s1_eol  <= i_end_of_line;
        end
    end

    // Advance the line state; clear it after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || load_out) begin
            r_phase       <= PH_BEFORE;
            r_digit_value <= '0;
            r_in_digits   <= 1'b0;
            r_count       <= '0;
            r_fault       <= 1'b0;
            r_addr        <= '0;
            r_port        <= '0;
        end else if (advance) begin
            r_phase       <= n_phase;
            r_digit_value <= n_digit_value;
            r_in_digits   <= n_in_digits;
            r_count       <= n_count;
            r_fault       <= n_fault;
            r_addr        <= n_addr;
            r_port        <= n_port;
        end
    end

    // Load the result and hold it while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (load_out) begin
            r_err     <= err_code;
            r_ip      <= (err_code == ERR_OK) ? n_addr : 32'd0;
            r_portnum <= (err_code == ERR_OK) ? n_port : 16'd0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_error_code  = r_err;
    assign o_ip_address  = r_ip;
    assign o_port_number = r_portnum;

endmodule

@@ hw/rtl/ftpep_checker.sv @@
// Port-level checks for the FTP endpoint parser, bound to the top level.
// Depends on ftpep_pkg and ftp_endpoint_parser_core.
`timescale 1ns / 1ps

module ftpep_checker
    import ftpep_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_end_of_line,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_error_code,
    input logic [31:0] o_ip_address,
    input logic [15:0] o_port_number
);

    // Hold a stalled result request unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_error_code)
            && $stable(o_ip_address) && $stable(o_port_number))
        else $error("stalled result request changed");

    // Zero address and port on every failed line
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != ERR_OK |-> o_ip_address == 32'd0
            && o_port_number == 16'd0)
        else $error("address or port set on a failed line");

    // Drop the result request and the input stall after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("valid or stall high after reset");

    // A byte without end of line never stalls the input on its own
    a_no_eol_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_end_of_line |=> !o_in_stall)
        else $error("input stalled behind a mid-line byte");

endmodule

bind ftp_endpoint_parser_core ftpep_checker u_ftpep_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_end_of_line (i_end_of_line),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_error_code  (o_error_code),
    .o_ip_address  (o_ip_address),
    .o_port_number (o_port_number)
);

@@ tb/sv/tb_ftp_endpoint_parser_core.sv @@
// Self-checking testbench for ftp_endpoint_parser_core: directed line table, then random
// PORT, PASV and noise lines checked against an in-bench line parser. Depends on ftpep_pkg and the RTL.
`timescale 1ns / 1ps

module tb_ftp_endpoint_parser_core;
    import ftpep_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int BYTE_TARGET   = 1300;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 12;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        t_err        err;
        logic [31:0] ip;
        logic [15:0] port;
    } t_endpoint;

    typedef struct packed {
        logic        mode;
        logic [7:0]  ch;
        logic        eol;
        logic        known_result;
        t_err        err;
        logic [31:0] ip;
        logic [15:0] port;
    } t_stim_row;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [7:0]  i_char_byte     = 8'h00;
    logic        i_end_of_line   = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic        i_cfg_line_mode = MODE_PORT;
    logic        i_out_stall     = 1'b0;
    logic        o_in_stall;
    logic        o_cfg_ready;
    logic        o_out_valid;
    logic [1:0]  o_error_code;
    logic [31:0] o_ip_address;
    logic [15:0] o_port_number;

    ftp_endpoint_parser_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_byte     (i_char_byte),
        .i_end_of_line   (i_end_of_line),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_line_mode (i_cfg_line_mode),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_error_code    (o_error_code),
        .o_ip_address    (o_ip_address),
        .o_port_number   (o_port_number)
    );

    // Directed lines: lone NUL and 0xFF bytes, PASV line without parentheses,
    // PASV "((9)9" with a nested open and a digit after the close, and a PORT line
    // whose last run saturates and is still open on the final byte.
    t_stim_row directed_rows [23] = '{
        '{MODE_PORT, 8'h00,      1'b1, 1'b1, ERR_FEW_NUMS, 32'h0, 16'h0},
        '{MODE_PORT, 8'hFF,      1'b1, 1'b1, ERR_FEW_NUMS, 32'h0, 16'h0},
        '{MODE_PASV, "5",        1'b1, 1'b1, ERR_NO_PAREN, 32'h0, 16'h0},
        '{MODE_PASV, CHAR_OPEN,  1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PASV, CHAR_OPEN,  1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PASV, "9",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PASV, CHAR_CLOSE, 1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PASV, "9",        1'b1, 1'b1, ERR_FEW_NUMS, 32'h0, 16'h0},
        '{MODE_PORT, "2",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, "5",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, "5",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, ",",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, "0",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, ",",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, "9",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, ",",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, "1",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, ",",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, "7",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, ",",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, "9",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, "9",        1'b0, 1'b0, ERR_OK,       32'h0, 16'h0},
        '{MODE_PORT, "9",        1'b1, 1'b1, ERR_RANGE,    32'h0, 16'h0}
    };

    // Parser state mirrored in the bench
    logic        mode_model  = MODE_PORT;
    t_phase      paren_st    = PH_BEFORE;
    logic [8:0]  run_value   = '0;
    logic        run_open    = 1'b0;
    logic [2:0]  fields_seen = '0;
    logic        over_range  = 1'b0;
    logic [31:0] addr_acc    = '0;
    logic [15:0] port_acc    = '0;

    t_endpoint   expected_endpoints [$];
    logic [7:0]  line_bytes [$];
    int          fail_count  = 0;
    int          bytes_sent  = 0;
    int          burst_left  = 0;
    int          cycle_count = 0;

    // Receiver pattern state
    int          seg_left      = 0;
    int          seg_kind      = 0;
    int          hold_left     = 0;
    int          results_taken = 0;
    logic        hold_done     = 1'b0;
    logic        stall_next    = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    // Append one byte to the line being built
    function automatic void add_line_byte(input logic [7:0] b);
        line_bytes.insert(line_bytes.size(), b);
    endfunction

    // Append one expected endpoint at the tail of the queue
    function automatic void add_expected(input t_endpoint ep);
        expected_endpoints.insert(expected_endpoints.size(), ep);
    endfunction

    // Close the current digit run into the address or port accumulator
    function automatic void close_number();
        if (run_value > 9'd255)
            over_range = 1'b1;
        if (fields_seen < ADDR_FIELDS)
            addr_acc = {addr_acc[23:0], run_value[7:0]};
        else if (fields_seen < NUM_FIELDS)
            port_acc = {port_acc[7:0], run_value[7:0]};
        if (fields_seen < COUNT_MAX)
            fields_seen = fields_seen + 3'd1;
        run_value = '0;
        run_open  = 1'b0;
    endfunction

    // Advance the line state by one byte; return 1 with the endpoint on the final byte
    function automatic logic track_line_byte(input logic [7:0] ch, input logic eol,
                                             output t_endpoint ep);
        logic [11:0] grown;
        logic        is_digit;
        logic        counting;
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        counting = (mode_model == MODE_PORT) || (paren_st == PH_INSIDE);
        ep = '{ERR_OK, 32'h0, 16'h0};
        if (is_digit && counting) begin
            grown     = {3'b000, run_value} * RADIX + {4'h0, ch - CHAR_ZERO};
            run_value = (grown > NUM_SAT_EXT) ? NUM_SAT : grown[8:0];
            run_open  = 1'b1;
        end else begin
            if (run_open)
                close_number();
            if (mode_model == MODE_PASV) begin
                if (paren_st == PH_BEFORE && ch == CHAR_OPEN)
                    paren_st = PH_INSIDE;
                else if (paren_st == PH_INSIDE && ch == CHAR_CLOSE)
                    paren_st = PH_AFTER;
            end
        end
        if (!eol)
            return 1'b0;
        if (run_open)
            close_number();
        if (mode_model == MODE_PASV && paren_st != PH_AFTER) begin
            ep.err = ERR_NO_PAREN;
        end else if (fields_seen < NUM_FIELDS) begin
            ep.err = ERR_FEW_NUMS;
        end else if (over_range) begin
            ep.err = ERR_RANGE;
        end else begin
            ep.ip   = addr_acc;
            ep.port = port_acc;
        end
        // Start the next line from scratch
        paren_st    = PH_BEFORE;
        run_value   = '0;
        run_open    = 1'b0;
        fields_seen = '0;
        over_range  = 1'b0;
        addr_acc    = '0;
        port_acc    = '0;
        return 1'b1;
    endfunction

    // Send one byte request, with a random gap at the start of each burst
    task automatic offer_byte(input logic [7:0] ch, input logic eol,
                              input logic use_known, input t_endpoint known_ep);
        t_endpoint predicted;
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_char_byte   <= ch;
        i_end_of_line <= eol;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        bytes_sent++;
        if (track_line_byte(ch, eol, predicted))
            add_expected(use_known ? known_ep : predicted);
    endtask

    // Drop valid, drain all results, then let the byte pipeline empty
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (expected_endpoints.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_mode(input logic m);
        i_cfg_valid     <= 1'b1;
        i_cfg_line_mode <= m;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        mode_model  = m;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void push_text(input string s);
        for (int k = 0; k < s.len(); k++)
            add_line_byte(s[k]);
    endfunction

    // Mostly in-range numbers, with zero, 255, saturating runs and leading zeros now and then
    function automatic void push_number();
        int pick;
        pick = $urandom_range(0, 59);
        case (pick)
            0: push_text("0");
            1: push_text("255");
            2: push_text("256");
            3: push_text($sformatf("%0d", $urandom_range(257, 999)));
            4: push_text($sformatf("000%0d", $urandom_range(0, 255)));
            5: push_text("99999");
            default: push_text($sformatf("%0d", $urandom_range(0, 255)));
        endcase
    endfunction

    function automatic string pick_separator();
        return ($urandom_range(0, 7) == 0) ? " " : ",";
    endfunction

    // Build one PORT, PASV or noise line and send it, sometimes flipping mode mid-line
    task automatic send_random_line();
        int         kind;
        int         count;
        int         split_at;
        logic       want;
        logic [7:0] junk;
        line_bytes.delete();
        kind  = $urandom_range(0, 9);
        count = 6;
        if ($urandom_range(0, 9) == 0)
            count = $urandom_range(0, 5);
        else if ($urandom_range(0, 9) == 0)
            count = $urandom_range(7, 8);
        if (kind < 4) begin
            want = MODE_PORT;
            if ($urandom_range(0, 1) == 1)
                push_text("PORT ");
            for (int n = 0; n < count; n++) begin
                if (n > 0)
                    push_text(pick_separator());
                push_number();
            end
        end else if (kind < 8) begin
            want = MODE_PASV;
            push_text("227 ");
            if ($urandom_range(0, 11) != 0)
                push_text("(");
            for (int n = 0; n < count; n++) begin
                if (n > 0)
                    push_text(pick_separator());
                if ($urandom_range(0, 19) == 0)
                    push_text("(");
                push_number();
            end
            if ($urandom_range(0, 11) != 0)
                push_text(")");
            if ($urandom_range(0, 2) == 0)
                push_text($sformatf(".%0d", $urandom_range(0, 999)));
        end else begin
            want = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 10)) begin
                if ($urandom_range(0, 2) == 0) begin
                    push_number();
                end else begin
                    junk = 8'($urandom_range(0, 255));
                    add_line_byte(junk);
                end
            end
        end
        if (line_bytes.size() == 0)
            push_text(".");
        if ($urandom_range(0, 9) == 0)
            want = !want;
        if (want != mode_model) begin
            settle_block();
            write_line_mode(want);
        end
        split_at = 0;
        if (line_bytes.size() > 1 && $urandom_range(0, 15) == 0)
            split_at = $urandom_range(1, line_bytes.size() - 1);
        for (int k = 0; k < line_bytes.size(); k++) begin
            if (split_at != 0 && k == split_at) begin
                settle_block();
                write_line_mode(!mode_model);
            end
            offer_byte(line_bytes[k], k == line_bytes.size() - 1, 1'b0, '0);
        end
    endtask

    // Compare one accepted result with the oldest expectation
    function automatic void check_endpoint();
        t_endpoint want;
        if (expected_endpoints.size() == 0) begin
            note_failure($sformatf("unexpected result: err %0d ip %h port %h",
                                   o_error_code, o_ip_address, o_port_number));
            return;
        end
        want = expected_endpoints.pop_front();
        if (o_error_code !== want.err)
            note_failure($sformatf("error_code: expected %0d, got %0d",
                                   want.err, o_error_code));
        if (o_ip_address !== want.ip)
            note_failure($sformatf("ip_address: expected %h, got %h",
                                   want.ip, o_ip_address));
        if (o_port_number !== want.port)
            note_failure($sformatf("port_number: expected %h, got %h",
                                   want.port, o_port_number));
    endfunction

    // Result side: check, then stall on random segments plus one long hold-off
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                check_endpoint();
                results_taken++;
            end
            if (!hold_done && results_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_kind = $urandom_range(0, 2);
                    seg_left = $urandom_range(1, 48);
                end
                seg_left--;
                case (seg_kind)
                    0: stall_next = 1'b0;
                    1: stall_next = 1'($urandom_range(0, 1));
                    default: stall_next = ($urandom_range(0, 3) != 0);
                endcase
            end
            i_out_stall <= stall_next;
        end
    end

    // Byte side: reset, directed table, random lines, drain and verdict
    initial begin
        t_endpoint known_ep;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_line_mode(MODE_PORT);
        foreach (directed_rows[r]) begin
            if (directed_rows[r].mode != mode_model) begin
                settle_block();
                write_line_mode(directed_rows[r].mode);
            end
            known_ep = '{directed_rows[r].err, directed_rows[r].ip, directed_rows[r].port};
            offer_byte(directed_rows[r].ch, directed_rows[r].eol,
                       directed_rows[r].known_result, known_ep);
        end
        while (bytes_sent < BYTE_TARGET)
            send_random_line();
        settle_block();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ftpep_pkg.sv
hw/rtl/ftp_endpoint_parser_core.sv
hw/rtl/ftpep_checker.sv
tb/sv/tb_ftp_endpoint_parser_core.sv
